// ===== rtl/core/y2r_pkg.sv =====
// shared constants, types and pixel math for the yuyv to rgb565 writer
package y2r_pkg;

  localparam int SRC_WIDTH     = 800;
  localparam int SRC_HEIGHT    = 600;
  localparam int PAIRS_PER_ROW = (SRC_WIDTH + 1) / 2;

  localparam int COL_W  = $clog2(PAIRS_PER_ROW + 1);
  localparam int ROW_W  = $clog2(SRC_HEIGHT + 1);
  localparam int ADDR_W = 22;
  localparam int FBW_W  = 13;
  localparam int PIX_W  = 16;
  localparam int BYTE_W = 8;
  localparam int SUM_W  = 20;
  localparam int OFF_W  = 10;

  localparam logic [FBW_W-1:0] FB_WIDTH_RESET = FBW_W'(800);

  localparam logic signed [OFF_W-1:0] LUMA_OFFSET   = OFF_W'(16);
  localparam logic signed [OFF_W-1:0] CHROMA_OFFSET = OFF_W'(128);
  localparam logic signed [SUM_W-1:0] COEF_Y    = SUM_W'(298);
  localparam logic signed [SUM_W-1:0] COEF_R_V  = SUM_W'(409);
  localparam logic signed [SUM_W-1:0] COEF_G_U  = SUM_W'(100);
  localparam logic signed [SUM_W-1:0] COEF_G_V  = SUM_W'(208);
  localparam logic signed [SUM_W-1:0] COEF_B_U  = SUM_W'(516);
  localparam logic signed [SUM_W-1:0] ROUND_ADD = SUM_W'(128);

  // one written macropixel waiting for color conversion
  typedef struct packed {
    logic [ADDR_W-1:0] word_address;
    logic [BYTE_W-1:0] luma_first;
    logic [BYTE_W-1:0] chroma_blue;
    logic [BYTE_W-1:0] luma_second;
    logic [BYTE_W-1:0] chroma_red;
    logic              frame_last;
  } pair_t;

  typedef struct packed {
    logic  push;
    pair_t pair;
  } push_t;

  function automatic logic [BYTE_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
    logic [SUM_W-9:0] shifted;
    shifted = sum[SUM_W-1:8];
    if (sum < 0) begin
      return '0;
    end else if (shifted > (SUM_W-8)'(255)) begin
      return 8'hff;
    end
    return shifted[BYTE_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] pack_rgb565(input logic [BYTE_W-1:0] r,
                                                   input logic [BYTE_W-1:0] g,
                                                   input logic [BYTE_W-1:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// ===== rtl/core/y2r_front.sv =====
// front end: raster counters, clipping, address generation and padding
module y2r_front import y2r_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fb_width_we_i,
  input  logic [FBW_W-1:0]  fb_width_i,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] luma_first_i,
  input  logic [BYTE_W-1:0] chroma_blue_i,
  input  logic [BYTE_W-1:0] luma_second_i,
  input  logic [BYTE_W-1:0] chroma_red_i,
  output push_t             push_o
);

  logic [FBW_W-1:0]  fb_width_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] addr_q, addr_d;

  logic [FBW_W:0]    fbw_ext;
  logic [FBW_W:0]    col_x2;
  logic [FBW_W:0]    col_next_x2;
  logic [FBW_W:0]    fb_pairs;
  logic [FBW_W:0]    pad_pairs;
  logic [ADDR_W-1:0] addr_inc;
  logic              write_en;
  logic              row_end;
  logic              last_row;
  logic              row_last_written;

  always_comb begin
    fbw_ext          = {1'b0, fb_width_q};
    col_x2           = (FBW_W+1)'({col_q, 1'b0});
    col_next_x2      = (FBW_W+1)'({col_q + COL_W'(1), 1'b0});
    fb_pairs         = (fbw_ext + (FBW_W+1)'(1)) >> 1;
    pad_pairs        = fb_pairs - (FBW_W+1)'(PAIRS_PER_ROW);
    write_en         = col_x2 < fbw_ext;
    row_end          = col_q == COL_W'(PAIRS_PER_ROW - 1);
    last_row         = row_q == ROW_W'(SRC_HEIGHT - 1);
    row_last_written = row_end || (col_next_x2 >= fbw_ext);

    addr_inc = write_en ? ADDR_W'(2) : '0;
    if (row_end && (fb_pairs > (FBW_W+1)'(PAIRS_PER_ROW))) begin
      addr_inc = addr_inc + ADDR_W'({pad_pairs, 1'b0});
    end

    col_d  = col_q;
    row_d  = row_q;
    addr_d = addr_q;
    if (accept_i) begin
      addr_d = addr_q + addr_inc;
      if (row_end) begin
        col_d = '0;
        if (last_row) begin
          row_d  = '0;
          addr_d = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end

    push_o.push              = accept_i && write_en;
    push_o.pair.word_address = addr_q;
    push_o.pair.luma_first   = luma_first_i;
    push_o.pair.chroma_blue  = chroma_blue_i;
    push_o.pair.luma_second  = luma_second_i;
    push_o.pair.chroma_red   = chroma_red_i;
    push_o.pair.frame_last   = last_row && row_last_written;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_width_q <= FB_WIDTH_RESET;
      col_q      <= '0;
      row_q      <= '0;
      addr_q     <= '0;
    end else begin
      if (fb_width_we_i) begin
        fb_width_q <= fb_width_i;
      end
      col_q  <= col_d;
      row_q  <= row_d;
      addr_q <= addr_d;
    end
  end

endmodule

// ===== rtl/core/y2r_queue.sv =====
// two-entry queue between the address front end and the color back end
module y2r_queue import y2r_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  not_empty_o,
  output pair_t head_o
);

  pair_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  always_comb begin
    full_o      = count_q == 2'd2;
    not_empty_o = count_q != 2'd0;
    do_push     = push_i.push && !full_o;
    do_pop      = pop_i && not_empty_o;
    count_d     = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
    head_o = entry_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.pair;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

// ===== rtl/core/y2r_back.sv =====
// back end: bt.601 products, sums and clamping, rgb565 packing, output register
module y2r_back import y2r_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  pair_t             in_pair_i,
  output logic              in_ready_o,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [ADDR_W-1:0] word_address_o,
  output logic [PIX_W-1:0]  pixel_even_o,
  output logic [PIX_W-1:0]  pixel_odd_o,
  output logic              frame_last_o
);

  // stage 1: products
  logic                     s1_valid_q;
  logic signed [SUM_W-1:0]  y0_q, y1_q, rv_q, gu_q, gv_q, bu_q;
  logic [ADDR_W-1:0]        s1_addr_q;
  logic                     s1_last_q;

  logic signed [OFF_W-1:0]  y0_off, y1_off, u_off, v_off;
  logic signed [SUM_W-1:0]  y0_d, y1_d, rv_d, gu_d, gv_d, bu_d;

  // stage 2: output register
  logic                     out_valid_q;
  logic [ADDR_W-1:0]        out_addr_q;
  logic [PIX_W-1:0]         out_even_q, out_odd_q;
  logic                     out_last_q;

  logic                     s2_ready;
  logic                     s1_ready;
  logic signed [SUM_W-1:0]  g_chroma;
  logic [PIX_W-1:0]         even_d, odd_d;

  always_comb begin
    s2_ready   = !out_valid_q || !stall_i;
    s1_ready   = !s1_valid_q || s2_ready;
    in_ready_o = s1_ready;

    y0_off = $signed({2'b00, in_pair_i.luma_first})  - LUMA_OFFSET;
    y1_off = $signed({2'b00, in_pair_i.luma_second}) - LUMA_OFFSET;
    u_off  = $signed({2'b00, in_pair_i.chroma_blue}) - CHROMA_OFFSET;
    v_off  = $signed({2'b00, in_pair_i.chroma_red})  - CHROMA_OFFSET;

    y0_d = SUM_W'(y0_off) * COEF_Y;
    y1_d = SUM_W'(y1_off) * COEF_Y;
    rv_d = SUM_W'(v_off) * COEF_R_V;
    gu_d = SUM_W'(u_off) * COEF_G_U;
    gv_d = SUM_W'(v_off) * COEF_G_V;
    bu_d = SUM_W'(u_off) * COEF_B_U;

    g_chroma = ROUND_ADD - gu_q - gv_q;
    even_d = pack_rgb565(clamp_channel(y0_q + rv_q + ROUND_ADD),
                         clamp_channel(y0_q + g_chroma),
                         clamp_channel(y0_q + bu_q + ROUND_ADD));
    odd_d  = pack_rgb565(clamp_channel(y1_q + rv_q + ROUND_ADD),
                         clamp_channel(y1_q + g_chroma),
                         clamp_channel(y1_q + bu_q + ROUND_ADD));

    valid_o        = out_valid_q;
    word_address_o = out_addr_q;
    pixel_even_o   = out_even_q;
    pixel_odd_o    = out_odd_q;
    frame_last_o   = out_last_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      y0_q      <= y0_d;
      y1_q      <= y1_d;
      rv_q      <= rv_d;
      gu_q      <= gu_d;
      gv_q      <= gv_d;
      bu_q      <= bu_d;
      s1_addr_q <= in_pair_i.word_address;
      s1_last_q <= in_pair_i.frame_last;
    end
    if (s1_valid_q && s2_ready) begin
      out_addr_q <= s1_addr_q;
      out_even_q <= even_d;
      out_odd_q  <= odd_d;
      out_last_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

endmodule

// ===== rtl/core/yuyv_to_rgb565_framebuffer_writer.sv =====
// top level of the yuyv macropixel to rgb565 framebuffer writer
//
// input channel: valid_i / stall_o with one yuyv macropixel (y0, cb, y1, cr) per
// transfer, in raster order of the source frame. output channel: valid_o / stall_i
// with the framebuffer word address of the first pixel and both rgb565 pixels;
// the second pixel belongs at the next word. frame_last_o marks the last written
// pair of a frame. macropixels left of the visible width give a result, the rest
// are taken and dropped.
// the user must write fb_width through fb_width_we_i / fb_width_i only while the
// block is idle; the block does not enforce this. throughput: one macropixel per
// clock unless stalled. the front end updates the counters in the accepting cycle,
// a two-entry queue follows, then one product stage and the output register.
// when the receiver stalls, the output register holds, the back end fills, and the
// queue absorbs two more items before stall_o rises.
// reset clears the counters and address, the pipeline, and sets fb_width to 800.
module yuyv_to_rgb565_framebuffer_writer import y2r_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fb_width_we_i,
  input  logic [FBW_W-1:0]  fb_width_i,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [BYTE_W-1:0] luma_first_i,
  input  logic [BYTE_W-1:0] chroma_blue_i,
  input  logic [BYTE_W-1:0] luma_second_i,
  input  logic [BYTE_W-1:0] chroma_red_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [ADDR_W-1:0] word_address_o,
  output logic [PIX_W-1:0]  pixel_even_o,
  output logic [PIX_W-1:0]  pixel_odd_o,
  output logic              frame_last_o
);

  push_t push;
  pair_t head;
  logic  queue_full;
  logic  queue_not_empty;
  logic  back_ready;
  logic  accept;

  assign stall_o = queue_full;
  assign accept  = valid_i && !queue_full;

  y2r_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fb_width_we_i (fb_width_we_i),
    .fb_width_i    (fb_width_i),
    .accept_i      (accept),
    .luma_first_i  (luma_first_i),
    .chroma_blue_i (chroma_blue_i),
    .luma_second_i (luma_second_i),
    .chroma_red_i  (chroma_red_i),
    .push_o        (push)
  );

  y2r_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (queue_full),
    .pop_i       (back_ready),
    .not_empty_o (queue_not_empty),
    .head_o      (head)
  );

  y2r_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (queue_not_empty),
    .in_pair_i      (head),
    .in_ready_o     (back_ready),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .word_address_o (word_address_o),
    .pixel_even_o   (pixel_even_o),
    .pixel_odd_o    (pixel_odd_o),
    .frame_last_o   (frame_last_o)
  );

`ifndef SYNTHESIS
  // the queue only fills up behind a stalled output
  a_full_after_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stall_o) |-> $past(valid_o && stall_i))
    else $error("queue filled without a stalled output");

  // a write-enabled item never arrives at a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push |-> !queue_full)
    else $error("push into full queue");

  // with an empty queue and an empty output register the input cannot be stalled next
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!queue_not_empty && !valid_o) |=> !stall_o)
    else $error("input stalled while back end was empty");
`endif

endmodule

// ===== sim/y2r_frame_checker.sv =====
// checker: predicts framebuffer writes from macropixel transfers and compares results
`timescale 1ns / 1ps

module y2r_frame_checker import y2r_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fb_width_we_i,
  input  logic [FBW_W-1:0]  fb_width_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [BYTE_W-1:0] luma_first_i,
  input  logic [BYTE_W-1:0] chroma_blue_i,
  input  logic [BYTE_W-1:0] luma_second_i,
  input  logic [BYTE_W-1:0] chroma_red_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [ADDR_W-1:0] word_address_i,
  input  logic [PIX_W-1:0]  pixel_even_i,
  input  logic [PIX_W-1:0]  pixel_odd_i,
  input  logic              frame_last_i,
  output int                mismatch_count_o,
  output int                pending_o
);

  typedef struct {
    logic [ADDR_W-1:0] word_address;
    logic [PIX_W-1:0]  pixel_even;
    logic [PIX_W-1:0]  pixel_odd;
    logic              frame_last;
  } fb_write_t;

  fb_write_t         expected_writes[$];
  logic [FBW_W-1:0]  fb_width_q;
  logic [ADDR_W-1:0] next_addr;
  int                col_pair;
  int                row_idx;
  int                errors;

  function automatic logic [BYTE_W-1:0] sat_byte(input int sum);
    if (sum < 0) return '0;
    if ((sum >>> 8) > 255) return 8'hff;
    return BYTE_W'(sum >>> 8);
  endfunction

  function automatic logic [PIX_W-1:0] to_rgb565(input logic [BYTE_W-1:0] luma,
                                                 input logic [BYTE_W-1:0] cb,
                                                 input logic [BYTE_W-1:0] cr);
    int y_term, du, dv;
    logic [BYTE_W-1:0] r, g, b;
    y_term = 298 * (int'(luma) - 16);
    du = int'(cb) - 128;
    dv = int'(cr) - 128;
    r = sat_byte(y_term + 409 * dv + 128);
    g = sat_byte(y_term - 100 * du - 208 * dv + 128);
    b = sat_byte(y_term + 516 * du + 128);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic void take_macropixel();
    fb_write_t w;
    int fb_pairs;
    if (2 * col_pair < int'(fb_width_q)) begin
      w.word_address = next_addr;
      w.pixel_even   = to_rgb565(luma_first_i, chroma_blue_i, chroma_red_i);
      w.pixel_odd    = to_rgb565(luma_second_i, chroma_blue_i, chroma_red_i);
      // last pair of the frame: last row and nothing more gets written in it
      w.frame_last   = (row_idx + 1 >= SRC_HEIGHT) &&
                       ((col_pair + 1 >= PAIRS_PER_ROW) ||
                        (2 * (col_pair + 1) >= int'(fb_width_q)));
      expected_writes.push_back(w);
      next_addr = next_addr + ADDR_W'(2);
    end
    col_pair++;
    if (col_pair >= PAIRS_PER_ROW) begin
      col_pair = 0;
      fb_pairs = (int'(fb_width_q) + 1) / 2;
      if (fb_pairs > PAIRS_PER_ROW) next_addr = next_addr + ADDR_W'(2 * (fb_pairs - PAIRS_PER_ROW));
      row_idx++;
      if (row_idx >= SRC_HEIGHT) begin
        row_idx   = 0;
        next_addr = '0;
      end
    end
  endfunction

  function automatic void check_write();
    fb_write_t w;
    if (expected_writes.size() == 0) begin
      $display("%0t: pixel pair expected none actual address %h", $time, word_address_i);
      errors++;
      return;
    end
    w = expected_writes.pop_front();
    if (word_address_i !== w.word_address) begin
      $display("%0t: word_address expected %h actual %h", $time, w.word_address, word_address_i);
      errors++;
    end
    if (pixel_even_i !== w.pixel_even) begin
      $display("%0t: pixel_even expected %h actual %h", $time, w.pixel_even, pixel_even_i);
      errors++;
    end
    if (pixel_odd_i !== w.pixel_odd) begin
      $display("%0t: pixel_odd expected %h actual %h", $time, w.pixel_odd, pixel_odd_i);
      errors++;
    end
    if (frame_last_i !== w.frame_last) begin
      $display("%0t: frame_last expected %b actual %b", $time, w.frame_last, frame_last_i);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_width_q = FB_WIDTH_RESET;
      next_addr  = '0;
      col_pair   = 0;
      row_idx    = 0;
      errors     = 0;
      expected_writes.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_write();
      if (in_valid_i && !in_stall_i) take_macropixel();
      // a width write counts from the next macropixel on
      if (fb_width_we_i) fb_width_q = fb_width_i;
      mismatch_count_o <= errors;
      pending_o        <= expected_writes.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// testbench top: clock, reset, macropixel stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb_top;
  import y2r_pkg::*;

  localparam int               CYCLE_LIMIT  = 2_000_000;
  localparam int               RANDOM_ITEMS = 540;
  localparam int               FB_CHOICES   = 11;
  localparam logic [FBW_W-1:0] FB_WIDEST    = FBW_W'(8191);

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              fb_we = 1'b0;
  logic [FBW_W-1:0]  fb_width = '0;
  logic              src_valid = 1'b0;
  logic              src_stall;
  logic [BYTE_W-1:0] y0 = '0;
  logic [BYTE_W-1:0] cb = '0;
  logic [BYTE_W-1:0] y1 = '0;
  logic [BYTE_W-1:0] cr = '0;
  logic              px_valid;
  logic              px_stall = 1'b0;
  logic [ADDR_W-1:0] px_addr;
  logic [PIX_W-1:0]  px_even;
  logic [PIX_W-1:0]  px_odd;
  logic              px_last;
  int                mismatches;
  int                pending;
  int                cycle_count = 0;

  // stimulus side bookkeeping
  int                items_sent;
  int                burst_left;
  int                gap_max;

  always #2 clk = ~clk;

  yuyv_to_rgb565_framebuffer_writer u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .fb_width_we_i (fb_we),
    .fb_width_i    (fb_width),
    .valid_i       (src_valid),
    .stall_o       (src_stall),
    .luma_first_i  (y0),
    .chroma_blue_i (cb),
    .luma_second_i (y1),
    .chroma_red_i  (cr),
    .valid_o       (px_valid),
    .stall_i       (px_stall),
    .word_address_o(px_addr),
    .pixel_even_o  (px_even),
    .pixel_odd_o   (px_odd),
    .frame_last_o  (px_last)
  );

  y2r_frame_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .fb_width_we_i   (fb_we),
    .fb_width_i      (fb_width),
    .in_valid_i      (src_valid),
    .in_stall_i      (src_stall),
    .luma_first_i    (y0),
    .chroma_blue_i   (cb),
    .luma_second_i   (y1),
    .chroma_red_i    (cr),
    .out_valid_i     (px_valid),
    .out_stall_i     (px_stall),
    .word_address_i  (px_addr),
    .pixel_even_i    (px_even),
    .pixel_odd_i     (px_odd),
    .frame_last_i    (px_last),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 5))
      0:       return BYTE_W'($urandom_range(0, 24));
      1:       return BYTE_W'($urandom_range(231, 255));
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [FBW_W-1:0] fb_choice(input int k);
    case (k)
      0:       return FBW_W'(4096);
      1:       return FBW_W'(801);
      2:       return FBW_W'(2);
      3:       return FBW_W'(799);
      4:       return FBW_W'(0);
      5:       return FB_WIDEST;
      6:       return FBW_W'(100);
      7:       return FBW_W'(1);
      8:       return FBW_W'(1000);
      9:       return FBW_W'(3);
      default: return FB_WIDTH_RESET;
    endcase
  endfunction

  // one macropixel transfer, with a random gap at the start of each burst
  task automatic send_pair(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
                           input logic [BYTE_W-1:0] c, input logic [BYTE_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        src_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    src_valid <= 1'b1;
    y0 <= a;
    cb <= b;
    y1 <= c;
    cr <= d;
    do @(posedge clk); while (src_stall);
    items_sent++;
  endtask

  task automatic send_random();
    send_pair(rand_byte(), rand_byte(), rand_byte(), rand_byte());
  endtask

  // hold the sender until every predicted write is out
  task automatic settle();
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_fb_width(input logic [FBW_W-1:0] w);
    settle();
    fb_we    <= 1'b1;
    fb_width <= w;
    @(posedge clk);
    fb_we  <= 1'b0;
  endtask

  // receiver: stall pattern in modes, plus one long hold once traffic is going
  initial begin : receiver
    int mode_left;
    int stall_pct;
    int results;
    bit held;
    mode_left = 0;
    stall_pct = 0;
    results   = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (px_valid && !px_stall) results++;
      if (!held && results >= 20) begin
        held = 1'b1;
        px_stall <= 1'b1;
        repeat (300) @(posedge clk);
        px_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(8, 64);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        mode_left--;
        px_stall <= ($urandom_range(1, 100) <= stall_pct);
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    items_sent = 0;
    burst_left = 0;
    gap_max    = 6;
    phase      = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, at the reset width: extremes, black, white, clamping on every channel
    send_pair(8'd0,   8'd0,   8'd0,   8'd0);
    send_pair(8'd255, 8'd255, 8'd255, 8'd255);
    send_pair(8'd16,  8'd128, 8'd16,  8'd128);
    send_pair(8'd235, 8'd128, 8'd235, 8'd128);
    send_pair(8'd255, 8'd0,   8'd0,   8'd255);
    send_pair(8'd0,   8'd255, 8'd255, 8'd0);
    send_pair(8'd128, 8'd0,   8'd128, 8'd255);
    send_pair(8'd128, 8'd255, 8'd128, 8'd0);
    send_pair(8'd81,  8'd90,  8'd145, 8'd240);
    send_pair(8'd16,  8'd128, 8'd235, 8'd128);
    send_pair(8'd255, 8'd128, 8'd0,   8'd128);
    send_pair(8'd15,  8'd127, 8'd17,  8'd129);
    send_pair(8'd170, 8'd85,  8'd85,  8'd170);

    // random pixels over a range of widths: odd, narrow, zero, beyond the source
    while (items_sent < RANDOM_ITEMS) begin
      set_fb_width(fb_choice(phase));
      phase = (phase + 1) % FB_CHOICES;
      n = $urandom_range(30, 120);
      repeat (n) send_random();
    end

    // back at the reset width
    set_fb_width(FB_WIDTH_RESET);
    repeat (60) send_random();

    src_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/y2r_pkg.sv
rtl/core/y2r_front.sv
rtl/core/y2r_queue.sv
rtl/core/y2r_back.sv
rtl/core/yuyv_to_rgb565_framebuffer_writer.sv
sim/y2r_frame_checker.sv
sim/tb_top.sv
